/* hw/rtl/act_pkg.sv */
// Shared types and constants for the adaptive command throttle.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package act_pkg;

    // Field widths of the command and response items
    localparam int OP_W       = 2;
    localparam int NOW_W      = 48;
    localparam int SLOT_W     = 48;
    localparam int WAIT_W     = 32;
    localparam int IVL_W      = 16;
    localparam int DELAY_W    = 22;
    localparam int FAIL_W     = 16;
    localparam int ATT_W      = 4;
    localparam int RETRY_W    = 5;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Default width of the internal time base
    localparam int TIME_BITS_DEF = 48;

    // Back-off step and exponent cap
    localparam int STEP_MS  = 100;
    localparam int EXP_CAP  = 5;
    localparam int EXTRA_W  = 12;    // holds STEP_MS shifted by EXP_CAP
    localparam int CAP_W    = 3;     // holds EXP_CAP

    localparam logic [FAIL_W-1:0]  FAIL_MAX    = '1;
    localparam logic [RETRY_W-1:0] RETRY_MIN   = 5'd1;
    localparam logic [RETRY_W-1:0] RETRY_MAX   = 5'd16;

    // Configuration reset values
    localparam logic [IVL_W-1:0]   BASE_RST    = 16'd100;
    localparam logic [IVL_W-1:0]   MAXI_RST    = 16'd2000;
    localparam logic [RETRY_W-1:0] RETRIES_RST = 5'd3;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_RESERVE = 2'd0,
        OP_SUCCESS = 2'd1,
        OP_FAILURE = 2'd2
    } t_op;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE    = 2'd0,
        REG_MAXI    = 2'd1,
        REG_RETRIES = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [IVL_W-1:0]   base_interval_ms;
        logic [IVL_W-1:0]   max_interval_ms;
        logic [RETRY_W-1:0] max_retries;
    } t_cfg;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot_ms;
        logic [WAIT_W-1:0]  wait_ms;
        logic [IVL_W-1:0]   interval_ms;
        logic [DELAY_W-1:0] retry_delay_ms;
        logic               give_up;
        logic [FAIL_W-1:0]  failure_count;
    } t_rsp;

endpackage

`default_nettype wire

/* hw/rtl/act_cmd_if.sv */
// Command channel of the throttle: valid/ready plus op and current time.
// Depends on act_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface act_cmd_if;
    import act_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [NOW_W-1:0]  now_ms;

    modport source (output valid, output op, output now_ms, input ready);
    modport sink   (input valid, input op, input now_ms, output ready);
endinterface

`default_nettype wire

/* hw/rtl/act_rsp_if.sv */
// Response channel of the throttle: valid/ready plus the result fields.
// Depends on act_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface act_rsp_if;
    import act_pkg::*;

    logic               valid;
    logic               ready;
    logic [SLOT_W-1:0]  slot_ms;
    logic [WAIT_W-1:0]  wait_ms;
    logic [IVL_W-1:0]   interval_ms;
    logic [DELAY_W-1:0] retry_delay_ms;
    logic               give_up;
    logic [FAIL_W-1:0]  failure_count;

    modport source (output valid, output slot_ms, output wait_ms, output interval_ms,
                    output retry_delay_ms, output give_up, output failure_count,
                    input ready);
    modport sink   (input valid, input slot_ms, input wait_ms, input interval_ms,
                    input retry_delay_ms, input give_up, input failure_count,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/act_cfg.sv */
// Configuration registers of the throttle: base, max interval, retry limit.
// Depends on act_pkg for the register indexes, reset values and t_cfg.
`timescale 1ns / 1ps
`default_nettype none

module act_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_we,
    input  wire logic [act_pkg::CFG_IDX_W-1:0]  i_idx,
    input  wire logic [act_pkg::CFG_DATA_W-1:0] i_data,
    output act_pkg::t_cfg                        o_cfg
);
    import act_pkg::*;

    t_cfg r_cfg;

    // Write the addressed register; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_interval_ms <= BASE_RST;
            r_cfg.max_interval_ms  <= MAXI_RST;
            r_cfg.max_retries      <= RETRIES_RST;
        end else if (i_we) begin
            unique case (i_idx)
                REG_BASE:    r_cfg.base_interval_ms <= i_data;
                REG_MAXI:    r_cfg.max_interval_ms  <= i_data;
                REG_RETRIES: r_cfg.max_retries      <= i_data[RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* hw/rtl/act_exec.sv */
// Throttle state and the single-pass result logic for one command item.
// Depends on act_pkg for t_cfg, t_rsp, op codes and constants.
`timescale 1ns / 1ps
`default_nettype none

module act_exec #(
    parameter int TIME_BITS = act_pkg::TIME_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_fire,
    input  wire logic [act_pkg::OP_W-1:0]   i_op,
    input  wire logic [act_pkg::NOW_W-1:0]  i_now_ms,
    input  act_pkg::t_cfg                   i_cfg,
    output act_pkg::t_rsp                   o_rsp
);
    import act_pkg::*;

    logic [TIME_BITS-1:0] r_next;
    logic [FAIL_W-1:0]    r_fails;
    logic [ATT_W-1:0]     r_att;
    logic [TIME_BITS-1:0] n_next;
    logic [FAIL_W-1:0]    n_fails;
    logic [ATT_W-1:0]     n_att;

    logic [TIME_BITS-1:0] now_t;
    logic [CAP_W-1:0]     capped;
    logic [IVL_W-1:0]     span;
    logic [IVL_W-1:0]     extra_raw;
    logic [IVL_W-1:0]     extra;
    logic [IVL_W-1:0]     spacing;
    logic                 next_ahead;
    logic [TIME_BITS-1:0] slot_t;
    logic [TIME_BITS:0]   sum_next;
    logic [TIME_BITS:0]   sum_now;
    logic [TIME_BITS:0]   sum_sel;
    logic [TIME_BITS-1:0] slot_end;
    logic [63:0]          diff64;
    logic [WAIT_W-1:0]    wait_sat;
    logic [RETRY_W-1:0]   limit;
    logic [FAIL_W-1:0]    fails_inc;
    logic [RETRY_W-1:0]   att_inc;
    logic [DELAY_W-1:0]   delay;

    // Take the time modulo the internal time base
    assign now_t = TIME_BITS'(64'(i_now_ms));

    // Spacing: base, plus a capped exponential extra once failures exist
    assign capped    = (r_fails < FAIL_W'(EXP_CAP)) ? r_fails[CAP_W-1:0] : CAP_W'(EXP_CAP);
    assign span      = (i_cfg.max_interval_ms > i_cfg.base_interval_ms)
                     ? i_cfg.max_interval_ms - i_cfg.base_interval_ms : '0;
    assign extra_raw = IVL_W'(EXTRA_W'(STEP_MS) << capped);
    assign extra     = (extra_raw > span) ? span : extra_raw;
    // Sum is at most the larger of base and max_interval_ms, so it cannot wrap
    assign spacing   = (r_fails == '0) ? i_cfg.base_interval_ms
                                       : i_cfg.base_interval_ms + extra;

    // Slot and next-allowed time: both candidate sums in parallel, then pick
    assign next_ahead = r_next > now_t;
    assign slot_t     = next_ahead ? r_next : now_t;
    assign sum_next   = {1'b0, r_next} + {{(TIME_BITS+1-IVL_W){1'b0}}, spacing};
    assign sum_now    = {1'b0, now_t} + {{(TIME_BITS+1-IVL_W){1'b0}}, spacing};
    assign sum_sel    = next_ahead ? sum_next : sum_now;
    assign slot_end   = sum_sel[TIME_BITS] ? '1 : sum_sel[TIME_BITS-1:0];

    // Wait until the slot, saturated to the wait field
    assign diff64   = 64'(slot_t - now_t);
    assign wait_sat = (|diff64[63:WAIT_W]) ? '1 : diff64[WAIT_W-1:0];

    // Failure handling: clamp the retry limit, saturate the failure count
    assign limit     = (i_cfg.max_retries < RETRY_MIN) ? RETRY_MIN
                     : (i_cfg.max_retries > RETRY_MAX) ? RETRY_MAX : i_cfg.max_retries;
    assign fails_inc = (r_fails == FAIL_MAX) ? r_fails : r_fails + 1'b1;
    assign att_inc   = {1'b0, r_att} + 1'b1;
    assign delay     = DELAY_W'(STEP_MS) << r_att;

    // Result and next state for the item in the input register
    always_comb begin
        n_next  = r_next;
        n_fails = r_fails;
        n_att   = r_att;
        o_rsp   = '0;
        case (i_op)
            OP_RESERVE: begin
                n_next            = slot_end;
                o_rsp.slot_ms     = SLOT_W'(64'(slot_t));
                o_rsp.wait_ms     = wait_sat;
                o_rsp.interval_ms = spacing;
            end
            OP_SUCCESS: begin
                n_fails = '0;
                n_att   = '0;
            end
            OP_FAILURE: begin
                o_rsp.retry_delay_ms = delay;
                if (att_inc >= limit) begin
                    // give up: the incremented count is at least one here
                    o_rsp.give_up = 1'b1;
                    n_fails       = fails_inc - 1'b1;
                    n_att         = '0;
                end else begin
                    n_fails = fails_inc;
                    n_att   = att_inc[ATT_W-1:0];
                end
            end
            default: ;
        endcase
        o_rsp.failure_count = n_fails;
    end

    // Advance the state when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next  <= '0;
            r_fails <= '0;
            r_att   <= '0;
        end else if (i_fire) begin
            r_next  <= n_next;
            r_fails <= n_fails;
            r_att   <= n_att;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/adaptive_command_throttle.sv */
// Adaptive command throttle: paces command slots and backs off on failures.
// Usage:
//   i_cmd carries one item per valid/ready handshake: op (reserve, success,
//   failure) and now_ms. o_rsp returns exactly one item per command, in order,
//   with slot, wait, spacing, retry delay, give-up flag and failure count.
//   The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) writes base
//   interval, max interval and retry limit; write it only while idle.
// Timing:
//   An accepted item lands in the input register, is evaluated in a single
//   pass and is then held in the output register, which drives o_rsp until
//   the receiver takes it. One item per cycle is sustained while o_rsp is
//   not stalled; the loop through the next-allowed register (one 48-bit
//   compare, add and select) sets the cycle time.
// Reset and stall:
//   Reset clears next-allowed time, failure count and attempt index and
//   loads the configuration defaults (100, 2000, 3). When o_rsp stalls the
//   result holds, the input register keeps one more item, and i_cmd.ready
//   drops only when both are full.
// Depends on act_pkg, act_cmd_if, act_rsp_if, act_cfg and act_exec.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_command_throttle #(
    parameter int TIME_BITS = act_pkg::TIME_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    act_cmd_if.sink                              i_cmd,
    act_rsp_if.source                            o_rsp,
    input  wire logic                            i_cfg_we,
    input  wire logic [act_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [act_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import act_pkg::*;

    t_cfg              cfg;
    t_rsp              rsp_c;
    t_rsp              r_rsp;
    logic              r_out_valid;
    logic              r_in_valid;
    logic [OP_W-1:0]   r_op;
    logic [NOW_W-1:0]  r_now;
    logic              out_load;
    logic              fire;
    logic              in_ready;

    // Pipeline flow control
    assign out_load = !r_out_valid || o_rsp.ready;
    assign fire     = r_in_valid && out_load;
    assign in_ready = !r_in_valid || out_load;

    act_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    act_exec #(
        .TIME_BITS (TIME_BITS)
    ) u_exec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_op     (r_op),
        .i_now_ms (r_now),
        .i_cfg    (cfg),
        .o_rsp    (rsp_c)
    );

    // Input register: take a new item whenever it is empty or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_cmd.valid) begin
            r_op  <= i_cmd.op;
            r_now <= i_cmd.now_ms;
        end
    end

    // Output register: hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rsp <= rsp_c;
        end
    end

    assign i_cmd.ready          = in_ready;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.slot_ms        = r_rsp.slot_ms;
    assign o_rsp.wait_ms        = r_rsp.wait_ms;
    assign o_rsp.interval_ms    = r_rsp.interval_ms;
    assign o_rsp.retry_delay_ms = r_rsp.retry_delay_ms;
    assign o_rsp.give_up        = r_rsp.give_up;
    assign o_rsp.failure_count  = r_rsp.failure_count;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking bench for adaptive_command_throttle: directed, random and stress items.
// Predicts every response in-bench and checks each field in order of arrival.
// Depends on act_pkg, act_cmd_if, act_rsp_if and the throttle RTL.
`timescale 1ns / 1ps

module tb_top;
    import act_pkg::*;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          TIME_W         = TIME_BITS_DEF;
    localparam logic [63:0] TIME_MAX       = (64'd1 << TIME_W) - 64'd1;
    localparam logic [63:0] WAIT_SAT       = 64'hFFFF_FFFF;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    act_cmd_if cmd_if ();
    act_rsp_if rsp_if ();

    adaptive_command_throttle u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predicted throttle state and configuration
    logic [63:0]        next_slot_ms;
    logic [FAIL_W-1:0]  fail_run;
    logic [RETRY_W-1:0] attempt_no;
    logic [IVL_W-1:0]   cfg_base;
    logic [IVL_W-1:0]   cfg_maxi;
    logic [RETRY_W-1:0] cfg_retries;

    t_rsp             pending_rsp[$];
    int               mismatch_cnt  = 0;
    int               send_idle_pct = 35;
    int               recv_idle_pct = 55;
    int               hold_len      = 0;
    int               stall_cycles  = 0;
    logic [NOW_W-1:0] clock_ms      = '0;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Compute the response of one command and advance the predicted state
    function automatic t_rsp predict_throttle(logic [OP_W-1:0] op, logic [NOW_W-1:0] now);
        t_rsp               r;
        logic [63:0]        slot;
        logic [63:0]        room;
        logic [63:0]        lag;
        logic [IVL_W-1:0]   ivl;
        logic [IVL_W-1:0]   span;
        logic [IVL_W-1:0]   extra;
        logic [CAP_W-1:0]   shift;
        logic [RETRY_W-1:0] limit;
        r = '0;
        case (op)
            OP_RESERVE: begin
                if (fail_run == '0) begin
                    ivl = cfg_base;
                end else begin
                    shift = (fail_run < EXP_CAP) ? fail_run[CAP_W-1:0] : CAP_W'(EXP_CAP);
                    span  = (cfg_maxi > cfg_base) ? cfg_maxi - cfg_base : '0;
                    extra = IVL_W'(STEP_MS) << shift;
                    if (extra > span) extra = span;
                    ivl = cfg_base + extra;
                end
                slot = (next_slot_ms > 64'(now)) ? next_slot_ms : 64'(now);
                room = TIME_MAX - slot;
                next_slot_ms = (64'(ivl) > room) ? TIME_MAX : slot + 64'(ivl);
                lag = slot - 64'(now);
                r.slot_ms     = slot[SLOT_W-1:0];
                r.wait_ms     = (lag > WAIT_SAT) ? '1 : lag[WAIT_W-1:0];
                r.interval_ms = ivl;
            end
            OP_SUCCESS: begin
                fail_run   = '0;
                attempt_no = '0;
            end
            OP_FAILURE: begin
                limit = cfg_retries;
                if (limit < RETRY_MIN) limit = RETRY_MIN;
                if (limit > RETRY_MAX) limit = RETRY_MAX;
                if (fail_run != FAIL_MAX) fail_run = fail_run + 1'b1;
                r.retry_delay_ms = DELAY_W'(STEP_MS) << attempt_no[ATT_W-1:0];
                attempt_no = attempt_no + 1'b1;
                if (attempt_no >= limit) begin
                    r.give_up = 1'b1;
                    if (fail_run != '0) fail_run = fail_run - 1'b1;
                    attempt_no = '0;
                end
            end
            default: ;
        endcase
        r.failure_count = fail_run;
        return r;
    endfunction

    function automatic void flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    function automatic void compare_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got) flag_mismatch(what, want, got);
    endfunction

    // Pick the next time stamp: mostly a slow forward drift, sometimes a jump or a stale time
    function automatic logic [NOW_W-1:0] next_now();
        int unsigned      pick;
        logic [NOW_W-1:0] back;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            clock_ms = clock_ms + NOW_W'({8'($urandom_range(0, 255)), 32'($urandom)});
            return clock_ms;
        end else if (pick < 8) begin
            back = NOW_W'($urandom) << $urandom_range(0, 12);
            return (clock_ms > back) ? clock_ms - back : '0;
        end
        clock_ms = clock_ms + NOW_W'($urandom_range(0, 400));
        return clock_ms;
    endfunction

    // Receive side: random back-pressure, or a counted hold-off when requested
    always @(posedge i_clk) begin
        if (hold_len != 0) begin
            rsp_if.ready <= 1'b0;
            hold_len     <= hold_len - 1;
        end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check each response against the oldest prediction
    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_rsp.size() == 0) begin
                flag_mismatch("item with none pending", 0, 1);
            end else begin
                want = pending_rsp.pop_front();
                compare_field("slot_ms", 64'(want.slot_ms), 64'(rsp_if.slot_ms));
                compare_field("wait_ms", 64'(want.wait_ms), 64'(rsp_if.wait_ms));
                compare_field("interval_ms", 64'(want.interval_ms), 64'(rsp_if.interval_ms));
                compare_field("retry_delay_ms", 64'(want.retry_delay_ms),
                              64'(rsp_if.retry_delay_ms));
                compare_field("give_up", 64'(want.give_up), 64'(rsp_if.give_up));
                compare_field("failure_count", 64'(want.failure_count),
                              64'(rsp_if.failure_count));
            end
        end
    end

    // Abort when nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one item after a random gap, hold it until taken, then predict its response
    task automatic send_cmd(logic [OP_W-1:0] op, logic [NOW_W-1:0] now);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid  <= 1'b1;
        cmd_if.op     <= op;
        cmd_if.now_ms <= now;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        pending_rsp.push_back(predict_throttle(op, now));
    endtask

    // Stop offering and wait until every predicted response has come back
    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [IVL_W-1:0] base, logic [IVL_W-1:0] maxi,
                             logic [RETRY_W-1:0] retries);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_BASE;
        i_cfg_data <= base;
        @(posedge i_clk);
        i_cfg_idx  <= REG_MAXI;
        i_cfg_data <= maxi;
        @(posedge i_clk);
        i_cfg_idx  <= REG_RETRIES;
        i_cfg_data <= CFG_DATA_W'(retries);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_base    = base;
        cfg_maxi    = maxi;
        cfg_retries = retries;
    endtask

    // Defaults after reset: spacing, back-off, give-up, success and the unused op
    task automatic test_basic_ops();
        send_cmd(OP_RESERVE, 48'd0);
        send_cmd(OP_RESERVE, 48'd0);
        send_cmd(OP_RESERVE, 48'd500);
        send_cmd(OP_FAILURE, '1);
        send_cmd(OP_RESERVE, 48'd600);
        send_cmd(OP_FAILURE, 48'd0);
        send_cmd(OP_FAILURE, 48'd0);
        send_cmd(OP_UNUSED, '1);
        send_cmd(OP_SUCCESS, 48'd0);
        send_cmd(OP_RESERVE, 48'd700);
        drain();
    endtask

    // Register extremes: zero and full intervals, max below base, retry limits out of range
    task automatic test_config_extremes();
        write_cfg(16'd0, 16'd0, 5'd0);
        send_cmd(OP_FAILURE, 48'd0);
        send_cmd(OP_FAILURE, 48'd0);
        send_cmd(OP_RESERVE, 48'd1000);
        drain();
        write_cfg(16'hFFFF, 16'd0, 5'd31);
        send_cmd(OP_FAILURE, 48'd0);
        send_cmd(OP_FAILURE, 48'd0);
        send_cmd(OP_RESERVE, 48'd1000);
        drain();
        write_cfg(16'd0, 16'hFFFF, 5'd16);
        repeat (7) send_cmd(OP_FAILURE, 48'd0);
        send_cmd(OP_RESERVE, 48'd2000);
        drain();
        write_cfg(16'd1000, 16'd1500, 5'd1);
        send_cmd(OP_SUCCESS, 48'd0);
        send_cmd(OP_FAILURE, 48'd0);
        send_cmd(OP_RESERVE, 48'd3000);
        drain();
    endtask

    // Commands as real traffic: reserve, then fail or succeed, with some stray items
    task automatic run_traffic(int n_items);
        int sent;
        int tries;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 6) begin
                send_cmd(OP_W'($urandom_range(0, 3)), next_now());
                sent++;
            end else begin
                tries = $urandom_range(1, 18);
                for (int k = 0; k < tries && sent < n_items; k++) begin
                    send_cmd(OP_RESERVE, next_now());
                    send_cmd((k == tries - 1 && $urandom_range(0, 2) != 0) ? OP_SUCCESS : OP_FAILURE,
                             next_now());
                    sent += 2;
                end
            end
        end
        drain();
    endtask

    task automatic test_random_traffic();
        logic [IVL_W-1:0]   base;
        logic [IVL_W-1:0]   maxi;
        logic [RETRY_W-1:0] retries;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 55 : 0;
            recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 35 : 0;
            for (int chunk = 0; chunk < 3; chunk++) begin
                if ($urandom_range(0, 9) < 6) begin
                    base = IVL_W'($urandom_range(0, 400));
                    maxi = IVL_W'($urandom_range(0, 5000));
                end else begin
                    base = IVL_W'($urandom);
                    maxi = IVL_W'($urandom);
                end
                retries = ($urandom_range(0, 3) == 0) ? RETRY_W'($urandom_range(0, 31))
                                                      : RETRY_W'($urandom_range(1, 6));
                write_cfg(base, maxi, retries);
                run_traffic(90);
            end
        end
    endtask

    // Hold the response side off long enough for the block to stall its input
    task automatic test_backpressure();
        hold_len <= 200;
        for (int k = 0; k < 24; k++)
            send_cmd(OP_W'($urandom_range(0, 2)), next_now());
        drain();
    endtask

    // Time near the top of the range: saturating next-allowed and wait; runs last
    // since next-allowed never comes down again
    task automatic test_time_extremes();
        write_cfg(16'd100, 16'd2000, 5'd3);
        send_cmd(OP_RESERVE, NOW_W'(TIME_MAX - 64'd50));
        send_cmd(OP_RESERVE, 48'd0);
        send_cmd(OP_FAILURE, 48'd0);
        send_cmd(OP_RESERVE, '1);
        repeat (40)
            send_cmd(OP_W'($urandom_range(0, 3)), {16'($urandom), 32'($urandom)});
        drain();
        write_cfg(16'd0, 16'd0, 5'd2);
        send_cmd(OP_SUCCESS, 48'd0);
        send_cmd(OP_RESERVE, '1);
        send_cmd(OP_RESERVE, 48'd0);
        drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_BASE;
        i_cfg_data    = '0;
        cmd_if.valid  = 1'b0;
        cmd_if.op     = OP_RESERVE;
        cmd_if.now_ms = '0;
        rsp_if.ready  = 1'b0;
        next_slot_ms  = '0;
        fail_run      = '0;
        attempt_no    = '0;
        cfg_base      = BASE_RST;
        cfg_maxi      = MAXI_RST;
        cfg_retries   = RETRIES_RST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_config_extremes();
        test_random_traffic();
        test_backpressure();
        test_time_extremes();

        if (mismatch_cnt == 0 && pending_rsp.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
